@@ rtl/adfs_pkg.sv @@
`default_nettype none

package adfs_pkg;

    localparam int BYTE_W    = 8;
    localparam int TYPE_W    = 8;
    localparam int OFF_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'd1;

    typedef struct packed {
        logic             record_found;
        logic [OFF_W-1:0] value_offset;
        logic [OFF_W-1:0] value_length;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/adv_data_field_search_top.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_payload_byte[7:0], s_final_byte
// m_        out        m_valid / m_ready  m_record_found, m_value_offset[4:0], m_value_length[4:0]
// cfg_      in         cfg_wr_en          cfg_index[0], cfg_wdata[7:0]
//
// A byte is taken per cycle when s_ready is high; the record walk updates in the accepting cycle.
// The item with s_final_byte set yields one result in the output register the next cycle.
// s_ready drops only while a result waits in the output register and m_ready is low.
// Reset (aresetn low at a clock edge) clears the walk state, config registers and output valid.
`default_nettype none

module adv_data_field_search_top #(
    parameter int MAX_PAYLOAD = 31
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [adfs_pkg::BYTE_W-1:0]   s_payload_byte,
    input  wire logic                          s_final_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_record_found,
    output logic [adfs_pkg::OFF_W-1:0]         m_value_offset,
    output logic [adfs_pkg::OFF_W-1:0]         m_value_length,
    input  wire logic                          cfg_wr_en,
    input  wire logic [adfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [adfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import adfs_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int NW = $clog2(MAX_PAYLOAD + 256);

    logic [TYPE_W-1:0] target_type_reg;
    logic [OFF_W-1:0]  start_offset_reg;

    logic [PW-1:0]     pos_reg, pos_next;
    logic [NW-1:0]     nrs_reg, nrs_next;
    logic [BYTE_W-1:0] cur_len_reg, cur_len_next;
    logic              match_reg, match_next;
    logic [PW-1:0]     mrs_reg, mrs_next;
    logic [BYTE_W-1:0] mlen_reg, mlen_next;

    logic              m_valid_reg;
    result_t           result_reg, result_next;

    logic              s_fire;
    logic [NW-1:0]     pos_ext;
    logic [NW-1:0]     nrs_adv;
    logic [NW-1:0]     val_off;
    logic [NW-1:0]     val_len;
    logic [NW-1:0]     val_end;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign pos_ext = NW'(pos_reg);
    assign nrs_adv = nrs_reg + NW'(cur_len_reg) + NW'(1);

    always_comb begin
        pos_next     = pos_reg;
        nrs_next     = nrs_reg;
        cur_len_next = cur_len_reg;
        match_next   = match_reg;
        mrs_next     = mrs_reg;
        mlen_next    = mlen_reg;
        if (pos_reg < PW'(MAX_PAYLOAD)) begin
            pos_next = pos_reg + PW'(1);
            if (!match_reg) begin
                if (pos_ext == nrs_reg) begin
                    cur_len_next = s_payload_byte;
                end else if (pos_ext == nrs_reg + NW'(1)) begin
                    if (nrs_reg >= NW'(start_offset_reg) && s_payload_byte == target_type_reg) begin
                        match_next = 1'b1;
                        mrs_next   = nrs_reg[PW-1:0];
                        mlen_next  = cur_len_reg;
                    end else begin
                        nrs_next = nrs_adv;
                        if (nrs_adv == pos_ext) begin
                            cur_len_next = s_payload_byte;
                        end
                    end
                end
            end
        end
    end

    assign val_off = NW'(mrs_next) + NW'(2);
    assign val_len = NW'(mlen_next) - NW'(1);
    assign val_end = val_off + val_len;

    always_comb begin
        result_next = '0;
        if (match_next && mlen_next > BYTE_W'(1) && val_end <= NW'(pos_next)
                && val_off <= NW'(OFF_MAX) && val_len <= NW'(OFF_MAX)) begin
            result_next.record_found = 1'b1;
            result_next.value_offset = val_off[OFF_W-1:0];
            result_next.value_length = val_len[OFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_type_reg  <= '0;
            start_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_TYPE:  target_type_reg  <= cfg_wdata[TYPE_W-1:0];
                CFG_START_OFFSET: start_offset_reg <= cfg_wdata[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            nrs_reg     <= '0;
            cur_len_reg <= '0;
            match_reg   <= 1'b0;
            mrs_reg     <= '0;
            mlen_reg    <= '0;
        end else if (s_fire) begin
            cur_len_reg <= cur_len_next;
            mrs_reg     <= mrs_next;
            mlen_reg    <= mlen_next;
            if (s_final_byte) begin
                pos_reg   <= '0;
                nrs_reg   <= '0;
                match_reg <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                nrs_reg   <= nrs_next;
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_final_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_final_byte) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_record_found = result_reg.record_found;
    assign m_value_offset = result_reg.value_offset;
    assign m_value_length = result_reg.value_length;

endmodule

`default_nettype wire

@@ rtl/adfs_checker.sv @@
`default_nettype none

module adfs_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      s_final_byte,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_record_found,
    input wire logic [adfs_pkg::OFF_W-1:0] m_value_offset,
    input wire logic [adfs_pkg::OFF_W-1:0] m_value_length
);
    import adfs_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_record_found)
            && $stable(m_value_offset) && $stable(m_value_length))
        else $error("result changed while stalled");

    a_final_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_byte |=> m_valid)
        else $error("final item gave no result");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_found |-> m_value_offset == '0 && m_value_length == '0)
        else $error("not-found result carries nonzero fields");

    a_found_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_found |-> m_value_length != '0 && m_value_offset >= OFF_W'(2))
        else $error("found result has empty value or impossible offset");

endmodule

bind adv_data_field_search_top adfs_checker u_adfs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_final_byte   (s_final_byte),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_record_found (m_record_found),
    .m_value_offset (m_value_offset),
    .m_value_length (m_value_length)
);

`default_nettype wire
